// ----- rtl/bkvt_pkg.sv -----
// Shared types, codes and defaults for the bounded key-value table.
// Used by bkvt_ctrl, bkvt_datapath and bounded_key_value_table_core; no dependencies.
package bkvt_pkg;

  // Default capacity of the table
  localparam int ENTRIES_DEF = 16;

  // Request codes (the unused code behaves as a lookup)
  localparam logic [1:0] REQ_INSERT = 2'd0;
  localparam logic [1:0] REQ_REMOVE = 2'd1;
  localparam logic [1:0] REQ_LOOKUP = 2'd2;

  // Result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_DUP     = 2'd2;
  localparam logic [1:0] ST_MISSING = 2'd3;

  // Input word
  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] key;
    logic signed [31:0] value;
  } req_t;

  // Result word
  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] found_value;
    logic [4:0]         entry_count;
  } res_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_APPEND,
    S_READ_LAST,
    S_MOVE,
    S_FINISH
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic       capture;
    logic       search_step;
    logic       rd_last;
    logic       write_append;
    logic       write_move;
    logic       load_result;
    logic [1:0] res_status;
    logic       res_use_value;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [1:0] req_type;
    logic       search_done;
    logic       hit;
    logic       full;
    logic       out_busy;
  } sts_t;

endpackage

// ----- rtl/bkvt_datapath.sv -----
// Datapath of the key-value table: key/value memories, count, search scan and result register.
// Depends on bkvt_pkg; driven by commands from bkvt_ctrl.
module bkvt_datapath #(
  parameter int ENTRIES = bkvt_pkg::ENTRIES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  bkvt_pkg::req_t in_word,
  input  bkvt_pkg::cmd_t cmd,
  output bkvt_pkg::sts_t sts,
  input  logic           out_stall,
  output logic           out_valid,
  output bkvt_pkg::res_t out_word
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTRIES);

  // Storage
  logic signed [31:0] key_mem [ENTRIES];
  logic signed [31:0] val_mem [ENTRIES];

  // Registers
  bkvt_pkg::req_t     req_r;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic               rd_vld_r;
  logic [IDX_W-1:0]   rd_idx_r;
  logic signed [31:0] rd_key_r, rd_val_r;
  logic               hit_r, full_r;
  logic [IDX_W-1:0]   slot_r;
  logic signed [31:0] fval_r;
  bkvt_pkg::res_t     res_r, res_nxt;
  logic               out_valid_r;

  // Scan and port control
  logic               more;
  logic               issue;
  logic               match;
  logic [CNT_W-1:0]   last;
  logic [IDX_W-1:0]   rd_addr;
  logic               rd_en;
  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  logic signed [31:0] wr_key, wr_val;
  logic [CNT_W+4:0]   cnt_ext;

  assign more  = idx_r < count_r;
  assign issue = cmd.search_step && !hit_r && more;
  assign match = rd_vld_r && !hit_r && (rd_key_r == req_r.key);
  assign last  = count_r - 1'b1;

  // One read port: scan index or last occupied slot
  assign rd_addr = cmd.rd_last ? last[IDX_W-1:0] : idx_r[IDX_W-1:0];
  assign rd_en   = issue || cmd.rd_last;

  // One write port: append at the end or move last pair into the freed slot
  always_comb begin
    wr_en   = cmd.write_append || cmd.write_move;
    wr_addr = cmd.write_move ? slot_r : count_r[IDX_W-1:0];
    wr_key  = cmd.write_move ? rd_key_r : req_r.key;
    wr_val  = cmd.write_move ? rd_val_r : req_r.value;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      key_mem[wr_addr] <= wr_key;
      val_mem[wr_addr] <= wr_val;
    end
    if (rd_en) begin
      rd_key_r <= key_mem[rd_addr];
      rd_val_r <= val_mem[rd_addr];
    end
  end

  // Next count and scan index
  always_comb begin
    count_nxt = count_r;
    if (cmd.write_append) begin
      count_nxt = count_r + 1'b1;
    end else if (cmd.write_move) begin
      count_nxt = last;
    end
    idx_nxt = idx_r;
    if (cmd.capture) begin
      idx_nxt = '0;
    end else if (issue) begin
      idx_nxt = idx_r + 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      idx_r       <= '0;
      rd_vld_r    <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r  <= count_nxt;
      idx_r    <= idx_nxt;
      rd_vld_r <= issue;
      if (cmd.capture) begin
        hit_r <= 1'b0;
      end else if (match) begin
        hit_r <= 1'b1;
      end
      if (cmd.load_result) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r  <= in_word;
      full_r <= count_r >= FULL_CNT;
    end
    if (issue) begin
      rd_idx_r <= idx_r[IDX_W-1:0];
    end
    if (match) begin
      slot_r <= rd_idx_r;
      fval_r <= rd_val_r;
    end
    if (cmd.load_result) begin
      res_r <= res_nxt;
    end
  end

  // Result word
  assign cnt_ext = {5'd0, count_r};
  always_comb begin
    res_nxt.status      = cmd.res_status;
    res_nxt.found_value = cmd.res_use_value ? fval_r : 32'sd0;
    res_nxt.entry_count = cnt_ext[4:0];
  end

  assign out_valid = out_valid_r;
  assign out_word  = res_r;

  // Status back to the controller
  always_comb begin
    sts.req_type    = req_r.req_type;
    sts.search_done = hit_r || (!rd_vld_r && !more);
    sts.hit         = hit_r;
    sts.full        = full_r;
    sts.out_busy    = out_valid_r && out_stall;
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("stored count exceeds capacity");

  a_append_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write_append |=> count_r == $past(count_r) + 1'b1)
    else $error("append did not grow the count by one");

  a_move_shrinks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.write_move |=> count_r == $past(count_r) - 1'b1)
    else $error("remove did not shrink the count by one");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(cmd.load_result))
    else $error("result valid without a load");

endmodule

// ----- rtl/bkvt_ctrl.sv -----
// Controller of the key-value table: sequences search, update and result load.
// Depends on bkvt_pkg; commands bkvt_datapath and reads its status.
module bkvt_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  bkvt_pkg::sts_t sts,
  output bkvt_pkg::cmd_t cmd
);

  bkvt_pkg::state_t state_r, state_nxt;
  logic is_insert, is_remove;

  assign is_insert = sts.req_type == bkvt_pkg::REQ_INSERT;
  assign is_remove = sts.req_type == bkvt_pkg::REQ_REMOVE;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bkvt_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      bkvt_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = bkvt_pkg::S_SEARCH;
        end
      end
      bkvt_pkg::S_SEARCH: begin
        cmd.search_step = 1'b1;
        if (sts.search_done) begin
          if (is_insert && !sts.full && !sts.hit) begin
            state_nxt = bkvt_pkg::S_APPEND;
          end else if (is_remove && sts.hit) begin
            state_nxt = bkvt_pkg::S_READ_LAST;
          end else begin
            state_nxt = bkvt_pkg::S_FINISH;
          end
        end
      end
      bkvt_pkg::S_APPEND: begin
        cmd.write_append = 1'b1;
        state_nxt        = bkvt_pkg::S_FINISH;
      end
      bkvt_pkg::S_READ_LAST: begin
        cmd.rd_last = 1'b1;
        state_nxt   = bkvt_pkg::S_MOVE;
      end
      bkvt_pkg::S_MOVE: begin
        cmd.write_move = 1'b1;
        state_nxt      = bkvt_pkg::S_FINISH;
      end
      bkvt_pkg::S_FINISH: begin
        // status: full beats duplicate on insert; anything else is hit or miss
        if (is_insert) begin
          if (sts.full) begin
            cmd.res_status = bkvt_pkg::ST_FULL;
          end else if (sts.hit) begin
            cmd.res_status = bkvt_pkg::ST_DUP;
          end else begin
            cmd.res_status = bkvt_pkg::ST_OK;
          end
        end else begin
          cmd.res_status = sts.hit ? bkvt_pkg::ST_OK : bkvt_pkg::ST_MISSING;
        end
        cmd.res_use_value = !is_insert && !is_remove && sts.hit;
        if (!sts.out_busy) begin
          cmd.load_result = 1'b1;
          state_nxt       = bkvt_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bkvt_pkg::S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/bounded_key_value_table_core.sv -----
// Bounded key-value table: an unsorted table of up to ENTRIES key/value pairs searched
// linearly. Insert appends unless the table is full (checked first) or the key is present;
// remove moves the last pair into the freed slot; lookup returns the stored value. Each
// request word gives one result word with status, value (nonzero only on a lookup hit) and
// the count after the request. Each request is searched first; an insert that appends then
// writes its pair, a successful remove reads the last pair and then moves it, and the result
// is loaded last. The search uses the single memory read port, scanning one stored key per
// cycle, and the read data is registered before it is compared with the requested key.
// A finished result waits in an output register, so the next request is accepted and
// searched meanwhile; it only waits before loading its own result while the earlier result
// is still stalled on the output.
// Depends on bkvt_pkg, bkvt_ctrl and bkvt_datapath.
module bounded_key_value_table_core #(
  parameter int ENTRIES = bkvt_pkg::ENTRIES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  bkvt_pkg::req_t in_word,
  output logic           out_valid,
  input  logic           out_stall,
  output bkvt_pkg::res_t out_word
);

  bkvt_pkg::cmd_t cmd;
  bkvt_pkg::sts_t sts;

  // Sequencer
  bkvt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Storage, scan and result
  bkvt_datapath #(
    .ENTRIES (ENTRIES)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_word   (in_word),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_word  (out_word)
  );

endmodule
